// ----- sv/av_interleave_framer_core_assert.svh -----
// Assertion macros shared by the framer RTL.
// Needs clk and arst_n in the scope of every use.
`ifndef AV_INTERLEAVE_FRAMER_CORE_ASSERT_SVH
`define AV_INTERLEAVE_FRAMER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Clocked property, off while reset is asserted
`define AV_IFR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
// Condition that must never hold at a clock edge
`define AV_IFR_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);
`else
`define AV_IFR_ASSERT(label, prop, msg)
`define AV_IFR_NEVER(label, expr, msg)
`endif

`endif

// ----- sv/av_ifr_pkg.sv -----
// Package for the A/V interleave framer: constants, payload structs,
// slot kind codes and the sync header byte lookup. No dependencies.
package av_ifr_pkg;

	// Framing constants
	localparam int VIDEO_PHASE     = 16384;
	localparam int AUDIO_PHASE     = 512;
	localparam int BLANK_TRANSFERS = 3;
	localparam int TRANSFER_BYTES  = 262144;
	localparam int FULL_PHASE      = VIDEO_PHASE + AUDIO_PHASE;

	localparam logic [31:0] MAGIC_A = 32'h8765_4321;
	localparam logic [31:0] MAGIC_B = 32'h1234_5678;

	// Field and counter widths
	localparam int LEFT_W  = 19;
	localparam int PHASE_W = $clog2(FULL_PHASE);
	localparam int HDR_W   = $clog2(AUDIO_PHASE);
	localparam int BLANK_W = $clog2(BLANK_TRANSFERS + 2);
	localparam int QUOT_MAX = (TRANSFER_BYTES - 1) / FULL_PHASE;
	localparam int QUOT_W  = (QUOT_MAX > 1) ? $clog2(QUOT_MAX + 1) : 1;

	// Reciprocal for an exact floor division by FULL_PHASE over LEFT_W-bit values
	localparam int RECIP_SHIFT = LEFT_W + $clog2(FULL_PHASE);
	localparam longint unsigned RECIP =
		((64'd1 << RECIP_SHIFT) + 64'(FULL_PHASE) - 64'd1) / 64'(FULL_PHASE);
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int PROD_W  = LEFT_W + RECIP_W;

	// Slot kind codes
	typedef enum logic [2:0] {
		KIND_BLANK = 3'd0,
		KIND_SYNC  = 3'd1,
		KIND_VIDEO = 3'd2,
		KIND_AUDIO = 3'd3,
		KIND_PAD   = 3'd4
	} kind_t;

	typedef struct packed {
		logic              transfer_start;
		logic [LEFT_W-1:0] bytes_left;
		logic              video_ready;
		logic [7:0]        video_byte;
		logic              audio_ready;
		logic [7:0]        audio_byte;
		logic              source_ended;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      byte_kind;
		logic       took_video;
		logic       took_audio;
		logic       stopped;
	} out_item_t;

	// Sync header: two magic words, header length, then zeros (little-endian)
	function automatic logic [7:0] header_byte(input logic [HDR_W-1:0] pos);
		logic [31:0] word;
		logic [7:0]  b;
		if (pos < HDR_W'(4)) word = MAGIC_A;
		else if (pos < HDR_W'(8)) word = MAGIC_B;
		else if (pos < HDR_W'(12)) word = 32'(AUDIO_PHASE);
		else word = '0;
		case (pos[1:0])
			2'd0: b = word[7:0];
			2'd1: b = word[15:8];
			2'd2: b = word[23:16];
			default: b = word[31:24];
		endcase
		return b;
	endfunction

endpackage

// ----- sv/av_ifr_pad_div.sv -----
// Whole phases covered by the rest of a transfer: floor((bytes_left-1)/FULL_PHASE),
// by reciprocal multiply. Depends on av_ifr_pkg.
module av_ifr_pad_div (
	input  logic [av_ifr_pkg::LEFT_W-1:0] bytes_left,
	output logic [av_ifr_pkg::QUOT_W-1:0] quot
);
	import av_ifr_pkg::*;

	logic [LEFT_W-1:0] left_m1;
	logic [PROD_W-1:0] prod;

	// Clamp to 1..TRANSFER_BYTES, then take one off
	always_comb begin
		if (bytes_left == '0) begin
			left_m1 = '0;
		end else if (32'(bytes_left) > TRANSFER_BYTES) begin
			left_m1 = LEFT_W'(TRANSFER_BYTES - 1);
		end else begin
			left_m1 = bytes_left - LEFT_W'(1);
		end
	end

	// Exact for every LEFT_W-bit dividend
	assign prod = PROD_W'(left_m1) * PROD_W'(RECIP);
	assign quot = QUOT_W'(prod >> RECIP_SHIFT);

endmodule

// ----- sv/av_ifr_seq.sv -----
// Framing sequencer: blanking, sync header, video/audio phases, padding, halt.
// Holds all framing state. Depends on av_ifr_pkg, av_ifr_pad_div.
`include "av_interleave_framer_core_assert.svh"

module av_ifr_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  av_ifr_pkg::in_item_t  item,
	output av_ifr_pkg::out_item_t result
);
	import av_ifr_pkg::*;

	logic [BLANK_W-1:0] blank_count_q, blank_count_d;
	logic               hdr_active_q, hdr_active_d;
	logic [HDR_W-1:0]   hdr_off_q, hdr_off_d;
	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [QUOT_W-1:0]  pad_quot_q, pad_quot_d;
	logic [PHASE_W-1:0] pad_cnt_q, pad_cnt_d;
	logic               halted_q, halted_d;

	logic [QUOT_W-1:0]  pad_quot;
	logic               pad_busy;
	logic               in_video;

	av_ifr_pad_div u_pad_div (
		.bytes_left(item.bytes_left),
		.quot      (pad_quot)
	);

	// Remaining padding = pad_quot_q * FULL_PHASE + pad_cnt_q
	assign pad_busy = (pad_cnt_q != '0) || (pad_quot_q != '0);
	assign in_video = phase_q < PHASE_W'(VIDEO_PHASE);

	// Next state and slot contents
	always_comb begin
		blank_count_d = blank_count_q;
		hdr_active_d  = hdr_active_q;
		hdr_off_d     = hdr_off_q;
		phase_d       = phase_q;
		pad_quot_d    = pad_quot_q;
		pad_cnt_d     = pad_cnt_q;
		halted_d      = halted_q;
		result        = '0;
		result.byte_kind = KIND_BLANK;

		// Transfer start: count blanking transfers, then open the header once
		if (!halted_q && item.transfer_start) begin
			if (blank_count_q < BLANK_W'(BLANK_TRANSFERS)) begin
				blank_count_d = blank_count_q + BLANK_W'(1);
			end else if (blank_count_q == BLANK_W'(BLANK_TRANSFERS)) begin
				blank_count_d = blank_count_q + BLANK_W'(1);
				hdr_active_d  = 1'b1;
				hdr_off_d     = '0;
				phase_d       = '0;
			end
		end

		if (halted_q) begin
			// stopped: zeros only
		end else if (hdr_active_d) begin
			result.out_byte  = header_byte(hdr_off_d);
			result.byte_kind = KIND_SYNC;
			if (hdr_off_d == HDR_W'(AUDIO_PHASE - 1)) begin
				hdr_active_d = 1'b0;
				hdr_off_d    = '0;
			end else begin
				hdr_off_d = hdr_off_d + HDR_W'(1);
			end
		end else if (blank_count_d <= BLANK_W'(BLANK_TRANSFERS)) begin
			// blanking transfer, or no transfer yet
		end else if (pad_busy) begin
			result.byte_kind = KIND_PAD;
			if (pad_cnt_q != '0) begin
				pad_cnt_d = pad_cnt_q - PHASE_W'(1);
			end else begin
				pad_quot_d = pad_quot_q - QUOT_W'(1);
				pad_cnt_d  = PHASE_W'(FULL_PHASE - 1);
			end
		end else if (in_video ? item.video_ready : item.audio_ready) begin
			if (in_video) begin
				result.out_byte   = item.video_byte;
				result.byte_kind  = KIND_VIDEO;
				result.took_video = 1'b1;
			end else begin
				result.out_byte   = item.audio_byte;
				result.byte_kind  = KIND_AUDIO;
				result.took_audio = 1'b1;
			end
			if (phase_q == PHASE_W'(FULL_PHASE - 1)) begin
				phase_d = '0;
			end else begin
				phase_d = phase_q + PHASE_W'(1);
			end
		end else if (item.source_ended) begin
			halted_d = 1'b1;
		end else begin
			// Underrun: this slot is the first pad byte
			result.byte_kind = KIND_PAD;
			pad_quot_d = pad_quot;
			pad_cnt_d  = PHASE_W'(FULL_PHASE - 1);
		end

		result.stopped = halted_d;
	end

	// State update, once per transfer through the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_count_q <= '0;
			hdr_active_q  <= 1'b0;
			hdr_off_q     <= '0;
			phase_q       <= '0;
			pad_quot_q    <= '0;
			pad_cnt_q     <= '0;
			halted_q      <= 1'b0;
		end else if (fire) begin
			blank_count_q <= blank_count_d;
			hdr_active_q  <= hdr_active_d;
			hdr_off_q     <= hdr_off_d;
			phase_q       <= phase_d;
			pad_quot_q    <= pad_quot_d;
			pad_cnt_q     <= pad_cnt_d;
			halted_q      <= halted_d;
		end
	end

	`AV_IFR_ASSERT(a_halt_sticky, halted_q |=> halted_q, "halt was released")
	`AV_IFR_ASSERT(a_hdr_after_blank, hdr_active_q |-> (blank_count_q == BLANK_W'(BLANK_TRANSFERS + 1)), "header active before blanking done")
	`AV_IFR_NEVER(a_one_source, result.took_video && result.took_audio, "both sources consumed in one slot")
	`AV_IFR_NEVER(a_phase_range, phase_q > PHASE_W'(FULL_PHASE - 1), "phase offset out of range")

endmodule

// ----- sv/av_interleave_framer_core.sv -----
// A/V interleave framer top level: input register, framing sequencer, result register.
// Path: an accepted item waits in the input register; its result is registered on fire.
// Throughput: one item per cycle while the result register is not held.
// Stalls: an item waits in the input register while the result register is held.
// Reset: arst_n clears all framing state and both pipeline valids asynchronously.
// Depends on av_ifr_pkg, av_ifr_seq.
`include "av_interleave_framer_core_assert.svh"

module av_interleave_framer_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  av_ifr_pkg::in_item_t  item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output av_ifr_pkg::out_item_t result
);
	import av_ifr_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result_s2;
	logic      valid_s2;

	out_item_t slot_result;
	logic      advance;
	logic      fire;
	logic      accept;

	// Handshake: result register frees up when empty or being taken
	assign advance    = !valid_s2 || !result_stall;
	assign fire       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	av_ifr_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.result(slot_result)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= slot_result;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	`AV_IFR_ASSERT(a_s1_held, (valid_s1 && !fire) |=> (valid_s1 && $stable(item_s1)), "pending item lost")
	`AV_IFR_ASSERT(a_fire_lands, fire |=> valid_s2, "processed slot not registered")
	`AV_IFR_ASSERT(a_accept_lands, accept |=> valid_s1, "accepted item not held")

endmodule

// ----- tb/sv/av_interleave_framer_core_check.sv -----
`timescale 1ns / 100ps
// Slot checker for av_interleave_framer_core: predicts each slot from accepted
// input transfers and compares the result transfers field by field.
// Depends on av_ifr_pkg.
module av_interleave_framer_core_check (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  item_stall,
	input  av_ifr_pkg::in_item_t  item,
	input  logic                  result_valid,
	input  logic                  result_stall,
	input  av_ifr_pkg::out_item_t result,
	output int                    mismatches,
	output int                    pending,
	output int                    bytes_taken,
	output logic                  halted
);
	import av_ifr_pkg::*;

	// Predicted framing state
	logic [BLANK_W-1:0] starts_seen;
	logic               hdr_on;
	logic [HDR_W-1:0]   hdr_pos;
	logic [PHASE_W-1:0] phase_pos;
	logic [LEFT_W-1:0]  pad_left;
	logic               stream_stopped;
	int                 taken_n;
	int                 fail_n;

	out_item_t slot_results_q[$];

	// Sync header: MAGIC_A, MAGIC_B, header length, all little-endian, then zeros
	function automatic logic [7:0] sync_header_byte(input logic [HDR_W-1:0] pos);
		logic [95:0] words;
		words = {32'(AUDIO_PHASE), MAGIC_B, MAGIC_A};
		if (pos >= HDR_W'(12))
			return 8'h00;
		return words[pos * 8 +: 8];
	endfunction

	task automatic note_mismatch(input string msg);
		fail_n++;
		$display("%0t: %s", $time, msg);
	endtask

	// Advance the predicted framer by one slot
	task automatic frame_slot(input in_item_t s, output out_item_t r);
		int   left;
		int   span;
		logic need_video;
		logic have;
		r = '0;
		r.byte_kind = KIND_BLANK;
		left = int'(s.bytes_left);
		if (left == 0)
			left = 1;
		if (left > TRANSFER_BYTES)
			left = TRANSFER_BYTES;

		// buffer start: count blank buffers, open the header on the next one
		if (!stream_stopped && s.transfer_start) begin
			if (starts_seen < BLANK_TRANSFERS) begin
				starts_seen++;
			end else if (starts_seen == BLANK_TRANSFERS) begin
				starts_seen++;
				hdr_on    = 1'b1;
				hdr_pos   = '0;
				phase_pos = '0;
			end
		end

		if (!stream_stopped) begin
			if (hdr_on) begin
				r.out_byte  = sync_header_byte(hdr_pos);
				r.byte_kind = KIND_SYNC;
				if (hdr_pos == HDR_W'(AUDIO_PHASE - 1)) begin
					hdr_on  = 1'b0;
					hdr_pos = '0;
				end else begin
					hdr_pos++;
				end
			end else if (starts_seen <= BLANK_TRANSFERS) begin
				r.byte_kind = KIND_BLANK;
			end else if (pad_left != '0) begin
				r.byte_kind = KIND_PAD;
				pad_left--;
			end else begin
				need_video = phase_pos < PHASE_W'(VIDEO_PHASE);
				have = need_video ? s.video_ready : s.audio_ready;
				if (have) begin
					if (need_video) begin
						r.out_byte   = s.video_byte;
						r.byte_kind  = KIND_VIDEO;
						r.took_video = 1'b1;
					end else begin
						r.out_byte   = s.audio_byte;
						r.byte_kind  = KIND_AUDIO;
						r.took_audio = 1'b1;
					end
					taken_n++;
					if (phase_pos == PHASE_W'(FULL_PHASE - 1))
						phase_pos = '0;
					else
						phase_pos++;
				end else if (s.source_ended) begin
					stream_stopped = 1'b1;
				end else begin
					// underrun: pad out the buffer rounded up to whole phases
					span = ((left + FULL_PHASE - 1) / FULL_PHASE) * FULL_PHASE;
					r.byte_kind = KIND_PAD;
					pad_left = LEFT_W'(span - 1);
				end
			end
		end
		r.stopped = stream_stopped;
	endtask

	// Watch both channels
	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		out_item_t next_slot;
		if (!arst_n) begin
			starts_seen    = '0;
			hdr_on         = 1'b0;
			hdr_pos        = '0;
			phase_pos      = '0;
			pad_left       = '0;
			stream_stopped = 1'b0;
			taken_n        = 0;
			fail_n         = 0;
			slot_results_q.delete();
			mismatches  <= 0;
			pending     <= 0;
			bytes_taken <= 0;
			halted      <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				frame_slot(item, next_slot);
				slot_results_q.push_back(next_slot);
			end
			if (result_valid && !result_stall) begin
				if (slot_results_q.size() == 0) begin
					note_mismatch($sformatf("result with nothing expected: byte %0d kind %0d",
						result.out_byte, result.byte_kind));
				end else begin
					want = slot_results_q.pop_front();
					if (result.out_byte !== want.out_byte)
						note_mismatch($sformatf("out_byte: got %0d, expected %0d",
							result.out_byte, want.out_byte));
					if (result.byte_kind !== want.byte_kind)
						note_mismatch($sformatf("byte_kind: got %0d, expected %0d",
							result.byte_kind, want.byte_kind));
					if (result.took_video !== want.took_video)
						note_mismatch($sformatf("took_video: got %0d, expected %0d",
							result.took_video, want.took_video));
					if (result.took_audio !== want.took_audio)
						note_mismatch($sformatf("took_audio: got %0d, expected %0d",
							result.took_audio, want.took_audio));
					if (result.stopped !== want.stopped)
						note_mismatch($sformatf("stopped: got %0d, expected %0d",
							result.stopped, want.stopped));
				end
			end
			mismatches  <= fail_n;
			pending     <= slot_results_q.size();
			bytes_taken <= taken_n;
			halted      <= stream_stopped;
		end
	end

endmodule

// ----- tb/sv/av_interleave_framer_core_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for av_interleave_framer_core: drives byte slots through the
// blank buffers, sync header, video stream and end of stream.
// Depends on av_ifr_pkg and av_interleave_framer_core_check.
module av_interleave_framer_core_tb;
	import av_ifr_pkg::*;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	in_item_t  item         = '0;
	logic      result_stall = 1'b0;
	logic      item_stall;
	logic      result_valid;
	out_item_t result;

	int   mismatches;
	int   pending;
	int   bytes_taken;
	logic halted;

	int sent_n  = 0;
	int cycle_n = 0;

	av_interleave_framer_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	av_interleave_framer_core_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.mismatches   (mismatches),
		.pending      (pending),
		.bytes_taken  (bytes_taken),
		.halted       (halted)
	);

	always #5 clk = ~clk;

	// Result side stalls at random, with one long quiet window
	always @(posedge clk) begin
		cycle_n <= cycle_n + 1;
		if (cycle_n >= 700 && cycle_n < 1300)
			result_stall <= 1'b0;
		else
			result_stall <= ($urandom_range(0, 99) < 14);
	end

	// Run limit
	initial begin
		#(64'd1_000_000);
		$display("av_interleave_framer_core: mismatch");
		$finish;
	end

	function automatic in_item_t noise_slot();
		in_item_t s;
		s.transfer_start = 1'($urandom());
		s.bytes_left     = LEFT_W'($urandom());
		s.video_ready    = 1'($urandom());
		s.video_byte     = 8'($urandom());
		s.audio_ready    = 1'($urandom());
		s.audio_byte     = 8'($urandom());
		s.source_ended   = 1'($urandom());
		return s;
	endfunction

	// Stream slot: the needed source is always ready.
	// est lags the true phase by at most one slot.
	function automatic in_item_t stream_slot(input int est);
		in_item_t s;
		s = noise_slot();
		s.video_ready = 1'b1;
		s.audio_ready = 1'b1;
		if (est < VIDEO_PHASE - 1)
			s.audio_ready = 1'($urandom());
		else if (est >= VIDEO_PHASE && est < FULL_PHASE - 1)
			s.video_ready = 1'($urandom());
		s.source_ended = ($urandom_range(0, 3) == 0);
		return s;
	endfunction

	// One input transfer, with random idle cycles ahead of it
	task automatic send_slot(input in_item_t s);
		while (!(sent_n >= 800 && sent_n < 1300) && $urandom_range(0, 99) < 14) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= s;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sent_n++;
	endtask

	initial begin
		in_item_t s;
		int       i;
		bit       drained;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// slots before any buffer start are blank
		repeat (4) begin
			s = noise_slot();
			s.transfer_start = 1'b0;
			send_slot(s);
		end

		// three blank buffers, bytes_left at its extremes
		s = noise_slot();
		s.transfer_start = 1'b1;
		s.bytes_left     = '0;
		send_slot(s);
		repeat (3) begin
			s = noise_slot();
			s.transfer_start = 1'b0;
			send_slot(s);
		end
		s = noise_slot();
		s.transfer_start = 1'b1;
		s.bytes_left     = '1;
		send_slot(s);
		repeat (2) begin
			s = noise_slot();
			s.transfer_start = 1'b0;
			send_slot(s);
		end
		s = noise_slot();
		s.transfer_start = 1'b1;
		s.bytes_left     = LEFT_W'(TRANSFER_BYTES);
		send_slot(s);

		// fourth start opens the sync header; extra starts inside it do nothing
		s = noise_slot();
		s.transfer_start = 1'b1;
		send_slot(s);
		for (i = 1; i < AUDIO_PHASE; i++) begin
			s = noise_slot();
			s.transfer_start = ($urandom_range(0, 15) == 0);
			send_slot(s);
		end

		// video stream, with one pause until every result is back
		drained = 1'b0;
		while (bytes_taken < 1150) begin
			if (!drained && bytes_taken >= 500) begin
				drained = 1'b1;
				item_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			send_slot(stream_slot(bytes_taken % FULL_PHASE));
		end

		// end of stream with no byte ready, then slots after the stop
		do begin
			s = noise_slot();
			s.video_ready  = 1'b0;
			s.audio_ready  = 1'b0;
			s.source_ended = 1'b1;
			send_slot(s);
		end while (!halted);
		repeat (40)
			send_slot(noise_slot());

		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("av_interleave_framer_core: match");
		else
			$display("av_interleave_framer_core: mismatch");
		$finish;
	end

endmodule
